/* design/mbet_pkg.sv */
// ----------------------------------------------------------------------------
// mbet_pkg: shared types and constants of the escape-time pixel unit
// Word format, register indexes, escape limit, scaling constants and the
// request/response structs of the multiplier and the divider.
// ----------------------------------------------------------------------------
`default_nettype none

package mbet_pkg;

   // signed fixed-point word
   localparam int WORD_W    = 32;
   localparam int FRAC_BITS = 28;

   // payload and register field widths
   localparam int COL_W     = 11;
   localparam int ITER_W    = 16;
   localparam int PIX_W     = 7;
   localparam int CSR_IDX_W = 3;

   // scaling: pixel = SCALE * remaining / max_iterations + 1
   localparam int SCALE     = 125;
   localparam int QUO_W     = 7;
   localparam int NUM_W     = 23;
   localparam int DSH_W     = ITER_W + QUO_W - 1;
   localparam int DCNT_W    = $clog2(QUO_W + 1);

   // |z|^2 bound of 4.0
   localparam logic signed [WORD_W:0] ESCAPE_LIMIT = (WORD_W + 1)'(1) << (FRAC_BITS + 2);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_X_FIRST        = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_X_INCREMENT    = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_Y_FIRST        = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_Y_INCREMENT    = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ITERATIONS = CSR_IDX_W'(4);

   // register reset values
   localparam logic [WORD_W-1:0] X_FIRST_RST     = WORD_W'(843314857);
   localparam logic [WORD_W-1:0] X_INCREMENT_RST = WORD_W'(-843314857);
   localparam logic [WORD_W-1:0] Y_FIRST_RST     = '0;
   localparam logic [WORD_W-1:0] Y_INCREMENT_RST = '0;
   localparam logic [ITER_W-1:0] MAX_ITER_RST    = ITER_W'(256);

   typedef enum logic {
      MUL_FRAC,   // fixed-point product, floor shift by FRAC_BITS
      MUL_INT     // integer product, low word
   } mul_mode_type;

   typedef struct packed {
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      mul_mode_type      mode;
   } mul_req_type;

   typedef struct packed {
      logic              start;
      logic [NUM_W-1:0]  numerator;
      logic [ITER_W-1:0] denominator;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

/* design/mbet_mul.sv */
// ----------------------------------------------------------------------------
// mbet_mul: shared signed multiplier
// One 32x32 signed product per cycle, registered; returns either the
// fixed-point word (floor shift) or the low integer word.
// ----------------------------------------------------------------------------
`default_nettype none

module mbet_mul
   import mbet_pkg::*;
(
   input  wire logic              clock,
   input  wire mul_req_type       req,
   output logic      [WORD_W-1:0] result
);

   logic signed [2*WORD_W-1:0] product;
   logic        [WORD_W-1:0]   result_in;
   logic        [WORD_W-1:0]   result_ff;

   always_comb begin
      product = $signed(req.a) * $signed(req.b);
      case (req.mode)
         MUL_FRAC: result_in = product[FRAC_BITS+WORD_W-1:FRAC_BITS];
         MUL_INT:  result_in = product[WORD_W-1:0];
         default:  result_in = product[WORD_W-1:0];
      endcase
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

`default_nettype wire

/* design/mbet_div.sv */
// ----------------------------------------------------------------------------
// mbet_div: restoring divider for pixel scaling
// One quotient bit per cycle; quotient is known to fit in QUO_W bits.
// ----------------------------------------------------------------------------
`default_nettype none

module mbet_div
   import mbet_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type req,
   output div_rsp_type      rsp
);

   logic              run_ff,  run_in;
   logic              done_ff, done_in;
   logic [DCNT_W-1:0] cnt_ff,  cnt_in;
   logic [NUM_W-1:0]  rem_ff,  rem_in;
   logic [DSH_W-1:0]  dsh_ff,  dsh_in;
   logic [QUO_W-1:0]  quo_ff,  quo_in;
   logic              fits;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      fits    = rem_ff >= NUM_W'(dsh_ff);
      if (req.start) begin
         run_in = 1'b1;
         cnt_in = DCNT_W'(QUO_W);
         rem_in = req.numerator;
         dsh_in = {req.denominator, (QUO_W - 1)'(0)};
         quo_in = '0;
      end else if (run_ff) begin
         // subtract the shifted divisor where it fits
         if (fits) begin
            rem_in = rem_ff - NUM_W'(dsh_ff);
         end
         quo_in = {quo_ff[QUO_W-2:0], fits};
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - DCNT_W'(1);
         if (cnt_ff == DCNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

`default_nettype wire

/* design/mandelbrot_escape_time_pixel_unit.sv */
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_unit: escape-time engine for one pixel at a time
// Iterates z = z*z + c in signed Q4.28 on one shared multiplier and scales
// the remaining round count to a 1..126 pixel value.
// ----------------------------------------------------------------------------
// One pixel is in work at a time; req_stall is high from the transfer of a
// column until its result has been handed to the output register. A pixel
// takes at most max_iterations rounds, the escaping round included: it
// forms the real part, runs the rounds, then does one scaling multiply,
// the divide (start, seven quotient bits, done) and loads the result. A
// zero iteration limit skips rounds and division and goes straight from
// forming the real part to loading the result.
// The rate is set by the single 32x32 signed multiplier, which serves the
// three products of every round in turn. The output register lets a new
// column be transferred while the previous result still waits on rsp_stall.
// Configuration writes are always taken (csr_ready is tied high); a write to
// y_first also restarts the frame at the first line.
// ----------------------------------------------------------------------------
`default_nettype none

module mandelbrot_escape_time_pixel_unit
   import mbet_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // pixel request channel
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [COL_W-1:0]     req_column,
   input  wire logic                 req_last_in_line,
   // pixel result channel
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic      [PIX_W-1:0]     rsp_pixel_value,
   output logic                      rsp_end_of_line,
   // register write channel
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [WORD_W-1:0]    csr_data
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_XMUL,       // column * x_increment in the multiplier
      ST_INIT,       // form c, seed z
      ST_SQ_RE,      // re*re issued; commit pending im update
      ST_SQ_IM,      // im*im issued; capture re^2
      ST_CROSS,      // re*im issued; escape test and re update
      ST_SCALE_MUL,  // remaining * 125
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_EMIT        // load output register when it is free
   } state_type;

   state_type         state_ff, state_in;

   // configuration
   logic [WORD_W-1:0] x_first_ff, x_first_in;
   logic [WORD_W-1:0] x_inc_ff,   x_inc_in;
   logic [WORD_W-1:0] y_first_ff, y_first_in;
   logic [WORD_W-1:0] y_inc_ff,   y_inc_in;
   logic [ITER_W-1:0] max_iter_ff, max_iter_in;
   logic [WORD_W-1:0] cur_imag_ff, cur_imag_in;

   // pixel in work
   logic [COL_W-1:0]  column_ff,  column_in;
   logic              last_ff,    last_in;
   logic [WORD_W-1:0] c_re_ff,    c_re_in;
   logic [WORD_W-1:0] c_im_ff,    c_im_in;
   logic [WORD_W-1:0] re_ff,      re_in;
   logic [WORD_W-1:0] im_ff,      im_in;
   logic [WORD_W-1:0] re_sq_ff,   re_sq_in;
   logic [ITER_W-1:0] iter_left_ff, iter_left_in;
   logic              first_ff,   first_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]  pixel_ff,     pixel_in;
   logic              eol_ff,       eol_in;

   mul_req_type       mul_req;
   logic [WORD_W-1:0] mul_q;
   div_req_type       div_req;
   div_rsp_type       div_rsp;

   logic              req_xfer;
   logic              csr_xfer;
   logic              out_free;
   logic signed [WORD_W:0] mag_sq;
   logic              escaped;

   mbet_mul u_mul (
      .clock  (clock),
      .req    (mul_req),
      .result (mul_q)
   );

   mbet_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign csr_xfer  = csr_valid && csr_ready;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // |z|^2 from the two wrapped squares, exact in one extra bit
   assign mag_sq  = $signed({re_sq_ff[WORD_W-1], re_sq_ff}) + $signed({mul_q[WORD_W-1], mul_q});
   assign escaped = mag_sq > ESCAPE_LIMIT;

   // steer the shared multiplier
   always_comb begin
      mul_req.a    = re_ff;
      mul_req.b    = re_ff;
      mul_req.mode = MUL_FRAC;
      case (state_ff)
         ST_XMUL: begin
            mul_req.a    = WORD_W'(column_ff);
            mul_req.b    = x_inc_ff;
            mul_req.mode = MUL_INT;
         end
         ST_SQ_IM: begin
            mul_req.a = im_ff;
            mul_req.b = im_ff;
         end
         ST_CROSS: begin
            mul_req.a = re_ff;
            mul_req.b = im_ff;
         end
         ST_SCALE_MUL: begin
            mul_req.a    = WORD_W'(iter_left_ff);
            mul_req.b    = WORD_W'(SCALE);
            mul_req.mode = MUL_INT;
         end
         default: begin
            mul_req.a = re_ff;
            mul_req.b = re_ff;
         end
      endcase
   end

   always_comb begin
      div_req.start       = (state_ff == ST_DIV_START);
      div_req.numerator   = mul_q[NUM_W-1:0];
      div_req.denominator = max_iter_ff;
   end

   always_comb begin
      state_in     = state_ff;
      x_first_in   = x_first_ff;
      x_inc_in     = x_inc_ff;
      y_first_in   = y_first_ff;
      y_inc_in     = y_inc_ff;
      max_iter_in  = max_iter_ff;
      cur_imag_in  = cur_imag_ff;
      column_in    = column_ff;
      last_in      = last_ff;
      c_re_in      = c_re_ff;
      c_im_in      = c_im_ff;
      re_in        = re_ff;
      im_in        = im_ff;
      re_sq_in     = re_sq_ff;
      iter_left_in = iter_left_ff;
      first_in     = first_ff;
      pixel_in     = pixel_ff;
      eol_in       = eol_ff;
      // drop the result once the consumer takes it
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      // register writes must arrive only while idle; the block does not enforce this
      if (csr_xfer) begin
         case (csr_index)
            CSR_X_FIRST:        x_first_in  = csr_data;
            CSR_X_INCREMENT:    x_inc_in    = csr_data;
            CSR_Y_FIRST: begin
               y_first_in  = csr_data;
               cur_imag_in = csr_data;
            end
            CSR_Y_INCREMENT:    y_inc_in    = csr_data;
            CSR_MAX_ITERATIONS: max_iter_in = csr_data[ITER_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               // capture the pixel and advance the line on its last pixel
               column_in = req_column;
               last_in   = req_last_in_line;
               c_im_in   = cur_imag_ff;
               if (req_last_in_line) begin
                  cur_imag_in = cur_imag_ff + y_inc_ff;
               end
               state_in = ST_XMUL;
            end
         end
         ST_XMUL: begin
            state_in = ST_INIT;
         end
         ST_INIT: begin
            c_re_in      = x_first_ff + mul_q;
            re_in        = x_first_ff + mul_q;
            im_in        = c_im_ff;
            iter_left_in = max_iter_ff;
            first_in     = 1'b1;
            state_in     = (max_iter_ff == '0) ? ST_EMIT : ST_SQ_RE;
         end
         ST_SQ_RE: begin
            // the cross product of the last round is out now
            if (!first_ff) begin
               im_in = (mul_q << 1) + c_im_ff;
            end
            first_in = 1'b0;
            state_in = ST_SQ_IM;
         end
         ST_SQ_IM: begin
            re_sq_in = mul_q;
            state_in = ST_CROSS;
         end
         ST_CROSS: begin
            if (escaped) begin
               state_in = ST_SCALE_MUL;
            end else begin
               re_in        = re_sq_ff - mul_q + c_re_ff;
               iter_left_in = iter_left_ff - ITER_W'(1);
               state_in     = (iter_left_ff == ITER_W'(1)) ? ST_SCALE_MUL : ST_SQ_RE;
            end
         end
         ST_SCALE_MUL: begin
            state_in = ST_DIV_START;
         end
         ST_DIV_START: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               eol_in       = last_ff;
               pixel_in     = (max_iter_ff == '0) ? PIX_W'(1)
                                                  : div_rsp.quotient + PIX_W'(1);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         x_first_ff   <= X_FIRST_RST;
         x_inc_ff     <= X_INCREMENT_RST;
         y_first_ff   <= Y_FIRST_RST;
         y_inc_ff     <= Y_INCREMENT_RST;
         max_iter_ff  <= MAX_ITER_RST;
         cur_imag_ff  <= Y_FIRST_RST;
         first_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         x_first_ff   <= x_first_in;
         x_inc_ff     <= x_inc_in;
         y_first_ff   <= y_first_in;
         y_inc_ff     <= y_inc_in;
         max_iter_ff  <= max_iter_in;
         cur_imag_ff  <= cur_imag_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      column_ff    <= column_in;
      last_ff      <= last_in;
      c_re_ff      <= c_re_in;
      c_im_ff      <= c_im_in;
      re_ff        <= re_in;
      im_ff        <= im_in;
      re_sq_ff     <= re_sq_in;
      iter_left_ff <= iter_left_in;
      pixel_ff     <= pixel_in;
      eol_ff       <= eol_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_value = pixel_ff;
   assign rsp_end_of_line = eol_ff;

`ifndef ASSERT_OFF
   // a transfer always starts work, so the next column must wait
   a_busy_after_xfer: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> req_stall)
      else $error("input not stalled after a column transfer");

   // rounds only run with iterations left
   a_rounds_have_budget: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQ_RE || state_ff == ST_SQ_IM || state_ff == ST_CROSS)
      |-> (iter_left_ff != '0 && iter_left_ff <= max_iter_ff))
      else $error("round running without remaining iterations");

   // scaled value stays within 1..126
   a_pixel_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pixel_value != '0 && rsp_pixel_value <= PIX_W'(SCALE + 1)))
      else $error("pixel value out of range");

   // the divider finishes only while awaited
   a_div_done_awaited: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == ST_DIV_WAIT)
      else $error("divider done outside its wait state");
`endif

endmodule

`default_nettype wire
